@@ rtl/lzssd_pkg.sv @@
// Shared types and constants for the LZSS decompressor.
`timescale 1ns / 1ps
`default_nettype none
package lzssd_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 4096;

  localparam logic        CMD_BYTE    = 1'b0;
  localparam logic        CMD_END     = 1'b1;
  localparam logic        KIND_DATA   = 1'b0;
  localparam logic        KIND_STATUS = 1'b1;
  localparam logic [3:0]  FLAG_EXPECT = 4'd8;
  localparam logic [4:0]  LEN_BIAS    = 5'd3;
  localparam logic [12:0] DIST_BIAS   = 13'd1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_byte;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_byte;
    logic       status;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic copy_rd;
    logic copy_wr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic copy_go;
    logic copy_last;
    logic out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

@@ rtl/lzssd_datapath.sv @@
// Datapath: token decode, history memory, copy pointers and output register.
`timescale 1ns / 1ps
`default_nettype none
module lzssd_datapath #(
  parameter int unsigned WINDOW_SIZE = lzssd_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lzssd_pkg::in_item_t  in_data,
  input  wire logic                 cfg_valid,
  input  wire logic [31:0]          cfg_data,
  input  wire lzssd_pkg::ctrl_cmd_t cmd,
  output lzssd_pkg::dp_stat_t       stat,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output lzssd_pkg::out_item_t      out_data
);

  localparam int unsigned AW = $clog2(WINDOW_SIZE);

  logic [7:0]  mem [WINDOW_SIZE];

  logic [31:0] exp_len_r;
  logic [31:0] count_r, count_nxt;
  logic [7:0]  flags_r, flags_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        await_r, await_nxt;
  logic [7:0]  code_lo_r, code_lo_nxt;
  logic        err_r, err_nxt;
  logic [4:0]  remain_r, remain_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [7:0]  rd_data_r;
  logic        out_valid_r, out_valid_nxt;
  lzssd_pkg::out_item_t out_r, out_nxt;

  logic        wr_en;
  logic [7:0]  wr_data;

  logic [12:0] match_dist;
  logic [4:0]  len;
  logic [31:0] room;
  logic        is_byte, live, is_flag, is_lit, is_code_hi, bad_match;

  assign match_dist = {1'b0, in_data.in_byte, code_lo_r[7:4]} + lzssd_pkg::DIST_BIAS;
  assign len     = {1'b0, code_lo_r[3:0]} + lzssd_pkg::LEN_BIAS;
  assign room    = exp_len_r - count_r;
  assign is_byte = (in_data.cmd == lzssd_pkg::CMD_BYTE);
  assign live    = is_byte && !err_r && (count_r < exp_len_r);
  assign is_flag = (pos_r == lzssd_pkg::FLAG_EXPECT);
  assign is_lit  = !is_flag && !flags_r[pos_r[2:0]];
  assign is_code_hi = !is_flag && flags_r[pos_r[2:0]] && await_r;
  assign bad_match  = ({19'd0, match_dist} > count_r) || ({27'd0, len} > room);

  assign stat.copy_go   = live && is_code_hi && !bad_match;
  assign stat.copy_last = (remain_r == 5'd1);
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    count_nxt     = count_r;
    flags_nxt     = flags_r;
    pos_nxt       = pos_r;
    await_nxt     = await_r;
    code_lo_nxt   = code_lo_r;
    err_nxt       = err_r;
    remain_nxt    = remain_r;
    rd_ptr_nxt    = rd_ptr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_data       = in_data.in_byte;

    if (cmd.accept) begin
      if (!is_byte) begin
        out_valid_nxt = 1'b1;
        out_nxt = '{result_kind: lzssd_pkg::KIND_STATUS, out_byte: 8'd0,
                    status: err_r || (count_r != exp_len_r), last_of_run: 1'b1};
        count_nxt   = '0;
        flags_nxt   = '0;
        pos_nxt     = lzssd_pkg::FLAG_EXPECT;
        await_nxt   = 1'b0;
        code_lo_nxt = '0;
        err_nxt     = 1'b0;
      end else if (err_r) begin
        err_nxt = 1'b1;
      end else if (!live) begin
        err_nxt = 1'b1;
      end else if (is_flag) begin
        flags_nxt = in_data.in_byte;
        pos_nxt   = '0;
      end else if (is_lit) begin
        out_valid_nxt = 1'b1;
        out_nxt = '{result_kind: lzssd_pkg::KIND_DATA, out_byte: in_data.in_byte,
                    status: 1'b0, last_of_run: 1'b1};
        wr_en     = 1'b1;
        count_nxt = count_r + 32'd1;
        pos_nxt   = pos_r + 4'd1;
      end else if (!await_r) begin
        code_lo_nxt = in_data.in_byte;
        await_nxt   = 1'b1;
      end else begin
        await_nxt = 1'b0;
        if (bad_match) begin
          err_nxt = 1'b1;
        end else begin
          remain_nxt = len;
          rd_ptr_nxt = count_r[AW-1:0] - match_dist[AW-1:0];
          pos_nxt    = pos_r + 4'd1;
        end
      end
    end

    if (cmd.copy_rd) begin
      rd_ptr_nxt = rd_ptr_r + {{(AW-1){1'b0}}, 1'b1};
    end

    if (cmd.copy_wr) begin
      out_valid_nxt = 1'b1;
      out_nxt = '{result_kind: lzssd_pkg::KIND_DATA, out_byte: rd_data_r,
                  status: 1'b0, last_of_run: (remain_r == 5'd1)};
      wr_en      = 1'b1;
      wr_data    = rd_data_r;
      count_nxt  = count_r + 32'd1;
      remain_nxt = remain_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r   <= '0;
      count_r     <= '0;
      flags_r     <= '0;
      pos_r       <= lzssd_pkg::FLAG_EXPECT;
      await_r     <= 1'b0;
      code_lo_r   <= '0;
      err_r       <= 1'b0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        exp_len_r <= cfg_data;
      end
      count_r     <= count_nxt;
      flags_r     <= flags_nxt;
      pos_r       <= pos_nxt;
      await_r     <= await_nxt;
      code_lo_r   <= code_lo_nxt;
      err_r       <= err_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_ptr_r <= rd_ptr_nxt;
    out_r    <= out_nxt;
  end

  // history window: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[AW-1:0]] <= wr_data;
    end
    if (cmd.copy_rd) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

endmodule
`default_nettype wire

@@ rtl/lzssd_ctrl.sv @@
// Controller: accepts input beats and sequences match copies.
`timescale 1ns / 1ps
`default_nettype none
module lzssd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lzssd_pkg::dp_stat_t  stat,
  output lzssd_pkg::ctrl_cmd_t      cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR
  } state_t;

  state_t state_r;

  assign in_ready    = (state_r == ST_IDLE) && stat.out_free;
  assign cmd.accept  = in_ready && in_valid;
  assign cmd.copy_rd = (state_r == ST_COPY_RD);
  assign cmd.copy_wr = (state_r == ST_COPY_WR) && stat.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (cmd.accept && stat.copy_go) begin
            state_r <= ST_COPY_RD;
          end
        end
        ST_COPY_RD: begin
          state_r <= ST_COPY_WR;
        end
        ST_COPY_WR: begin
          if (stat.out_free) begin
            state_r <= stat.copy_last ? ST_IDLE : ST_COPY_RD;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/lzss_decompressor_core.sv @@
// Top level of the LZSS decompressor (12-bit distance, 4-bit length).
// A literal or end beat shows its result in the cycle after acceptance.
// Flag, code and literal beats are taken while idle and the output is free; a
// match of 3 to 18 bytes reads history, then writes and emits, for each byte.
// Reset clears all control state; the history memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module lzss_decompressor_core #(
  parameter int unsigned WINDOW_SIZE = lzssd_pkg::WINDOW_SIZE_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lzssd_pkg::in_item_t in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lzssd_pkg::out_item_t     out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [31:0]         cfg_data
);

  lzssd_pkg::ctrl_cmd_t cmd;
  lzssd_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  lzssd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzssd_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
